[design/rebi_pkg.sv]
// Shared types, codes and the quadrature transition table for the encoder/button block.
package rebi_pkg;

   typedef enum logic [1:0] {
      OP_POLL    = 2'd0,
      OP_FLUSH   = 2'd1,
      OP_CAPTURE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_DETENT_DIVIDER = 2'd0,
      CSR_STEP_COOLDOWN  = 2'd1,
      CSR_DEBOUNCE       = 2'd2,
      CSR_LONG_PRESS     = 2'd3
   } csr_index_type;

   localparam int NOW_BITS  = 32;
   localparam int CSR_BITS  = 16;
   localparam int DIV_BITS  = 8;

   typedef logic signed [1:0] delta_type;

   // Indexed by {last_phase, current_phase}
   localparam delta_type TRANS_TAB [16] = '{
      2'sb00, 2'sb11, 2'sb01, 2'sb00,
      2'sb01, 2'sb00, 2'sb00, 2'sb11,
      2'sb11, 2'sb00, 2'sb00, 2'sb01,
      2'sb00, 2'sb01, 2'sb11, 2'sb00
   };

   typedef struct packed {
      logic [1:0]          opcode;
      logic                phase_a;
      logic                phase_b;
      logic                button_level;
      logic [NOW_BITS-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic signed [1:0] step;
      logic              short_press;
      logic              long_press;
   } rsp_type;

   typedef struct packed {
      logic [DIV_BITS-1:0] detent_divider;
      logic [CSR_BITS-1:0] step_cooldown_ms;
      logic [CSR_BITS-1:0] debounce_ms;
      logic [CSR_BITS-1:0] long_press_ms;
   } cfg_type;

endpackage

[design/rebi_channels.sv]
// Valid/ready channel interfaces for poll items, results and register writes.
interface rebi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic        phase_a;
   logic        phase_b;
   logic        button_level;
   logic [31:0] now_ms;

   modport source (output valid, opcode, phase_a, phase_b, button_level, now_ms,
                   input ready);
   modport sink   (input valid, opcode, phase_a, phase_b, button_level, now_ms,
                   output ready);
endinterface

interface rebi_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [1:0] step;
   logic              short_press;
   logic              long_press;

   modport source (output valid, step, short_press, long_press, input ready);
   modport sink   (input valid, step, short_press, long_press, output ready);
endinterface

interface rebi_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[design/rotary_encoder_button_input.sv]
// Quadrature rotary encoder decoder with debounced push button: top level.
//
// req_bus carries one poll item per beat: opcode (poll, flush, capture phase),
// the two encoder phases, the raw button level (low = pressed) and a wrapping
// millisecond timestamp. rsp_bus returns exactly one result beat per item:
// a detent step of -1/0/+1 plus short- and long-press flags.
// csr_bus writes the four timing/divider registers; it is always ready and
// should only be written while no items are in flight.
//
// A req beat reaches the rsp beat through two registers: the input register,
// then the decode/debounce logic feeding the result register. Throughput is one
// item per cycle while rsp_ready is high; the per-item state update is a single
// pass through the core. When rsp_ready is low the result register holds, the
// input register fills, and req_ready drops only once both are occupied.
// Reset (synchronous, active high) empties both registers, restores register
// defaults (divider 4, cooldown 50, debounce 30, long press 600) and returns the
// decoder to phase 3, zero count, button released.
module rotary_encoder_button_input #(
   parameter int TIME_BITS  = 32,
   parameter int ACCUM_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   rebi_req_if.sink   req_bus,
   rebi_rsp_if.source rsp_bus,
   rebi_csr_if.sink   csr_bus
);
   import rebi_pkg::*;

   req_type item_ff, item_in;
   logic    item_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;
   cfg_type cfg;
   logic    fire;
   logic    take;

   assign fire = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || fire;
   assign take = req_bus.valid && req_bus.ready;

   assign item_in = '{opcode:       req_bus.opcode,
                      phase_a:      req_bus.phase_a,
                      phase_b:      req_bus.phase_b,
                      button_level: req_bus.button_level,
                      now_ms:       req_bus.now_ms};

   assign csr_bus.ready = 1'b1;

   rebi_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   rebi_core #(
      .TIME_BITS  (TIME_BITS),
      .ACCUM_BITS (ACCUM_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            item_valid_ff <= 1'b1;
         end else if (fire) begin
            item_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.step        = rsp_ff.step;
   assign rsp_bus.short_press = rsp_ff.short_press;
   assign rsp_bus.long_press  = rsp_ff.long_press;

endmodule

[design/rebi_csr.sv]
// Configuration register file: divider, step cooldown, debounce and long-press times.
module rebi_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [1:0]           wr_index,
   input  logic [15:0]          wr_data,
   output rebi_pkg::cfg_type    cfg
);
   import rebi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DETENT_DIVIDER: cfg_in.detent_divider   = wr_data[DIV_BITS-1:0];
            CSR_STEP_COOLDOWN:  cfg_in.step_cooldown_ms = wr_data;
            CSR_DEBOUNCE:       cfg_in.debounce_ms      = wr_data;
            CSR_LONG_PRESS:     cfg_in.long_press_ms    = wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detent_divider   <= DIV_BITS'(4);
         cfg_ff.step_cooldown_ms <= CSR_BITS'(50);
         cfg_ff.debounce_ms      <= CSR_BITS'(30);
         cfg_ff.long_press_ms    <= CSR_BITS'(600);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/rebi_core.sv]
// Decoder state and the single-pass next-state/result logic for one item.
module rebi_core #(
   parameter int TIME_BITS  = 32,
   parameter int ACCUM_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rebi_pkg::req_type item,
   input  rebi_pkg::cfg_type cfg,
   output rebi_pkg::rsp_type result
);
   import rebi_pkg::*;

   localparam int SUM_BITS = ACCUM_BITS + 1;
   localparam logic signed [SUM_BITS-1:0] ACC_MAX = SUM_BITS'((1 << (ACCUM_BITS - 1)) - 1);
   localparam logic signed [SUM_BITS-1:0] ACC_MIN = -ACC_MAX - SUM_BITS'(1);

   logic [1:0]                   last_phase_ff, last_phase_in;
   logic signed [ACCUM_BITS-1:0] accum_ff, accum_in;
   logic [TIME_BITS-1:0]         last_step_ff, last_step_in;
   logic                         last_reading_ff, last_reading_in;
   logic [TIME_BITS-1:0]         last_change_ff, last_change_in;
   logic [TIME_BITS-1:0]         press_start_ff, press_start_in;
   logic                         held_ff, held_in;
   logic                         long_fired_ff, long_fired_in;

   logic [1:0]                   cur;
   logic [TIME_BITS-1:0]         now_t;
   logic signed [SUM_BITS-1:0]   sum;
   logic signed [ACCUM_BITS-1:0] accum_mid;
   logic [SUM_BITS-1:0]          mag;
   logic [SUM_BITS-1:0]          div;
   logic                         step_fire;
   logic [TIME_BITS-1:0]         since_step, since_change, since_press;
   logic                         stable, press_evt, release_evt;
   logic                         sp, lp;

   assign cur   = {item.phase_a, item.phase_b};
   assign now_t = TIME_BITS'(item.now_ms);

   assign sum = SUM_BITS'(accum_ff) + SUM_BITS'(TRANS_TAB[{last_phase_ff, cur}]);

   always_comb begin
      if (cur == last_phase_ff) begin
         accum_mid = accum_ff;
      end else if (sum > ACC_MAX) begin
         accum_mid = ACCUM_BITS'(ACC_MAX);
      end else if (sum < ACC_MIN) begin
         accum_mid = ACCUM_BITS'(ACC_MIN);
      end else begin
         accum_mid = ACCUM_BITS'(sum);
      end
   end

   // Extra bit keeps the magnitude of the most negative value
   assign mag = accum_mid[ACCUM_BITS-1] ? -SUM_BITS'(accum_mid) : SUM_BITS'(accum_mid);
   assign div = (cfg.detent_divider == '0) ? SUM_BITS'(1) : SUM_BITS'(cfg.detent_divider);

   assign since_step   = now_t - last_step_ff;
   assign since_change = now_t - last_change_ff;
   assign since_press  = now_t - press_start_ff;

   assign step_fire = (mag >= div) && (since_step > TIME_BITS'(cfg.step_cooldown_ms));

   // A level change restarts the debounce window, so it can never be stable on that poll
   assign stable      = (item.button_level == last_reading_ff) &&
                        (since_change > TIME_BITS'(cfg.debounce_ms));
   assign press_evt   = stable && !item.button_level && !held_ff;
   assign release_evt = stable && item.button_level && held_ff;
   assign sp          = release_evt && (since_press < TIME_BITS'(cfg.long_press_ms));
   assign lp          = held_ff && !long_fired_ff && !release_evt &&
                        (since_press > TIME_BITS'(cfg.long_press_ms));

   always_comb begin
      last_phase_in   = last_phase_ff;
      accum_in        = accum_ff;
      last_step_in    = last_step_ff;
      last_reading_in = last_reading_ff;
      last_change_in  = last_change_ff;
      press_start_in  = press_start_ff;
      held_in         = held_ff;
      long_fired_in   = long_fired_ff;
      result          = '0;
      case (item.opcode)
         OP_FLUSH: begin
            accum_in      = '0;
            long_fired_in = 1'b0;
         end
         OP_CAPTURE: begin
            last_phase_in = cur;
         end
         OP_POLL: begin
            last_phase_in = cur;
            if (step_fire) begin
               accum_in     = '0;
               last_step_in = now_t;
               result.step  = (accum_mid > 0) ? 2'sb01 : 2'sb11;
            end else begin
               accum_in = accum_mid;
            end
            if (item.button_level != last_reading_ff) begin
               last_change_in = now_t;
            end
            last_reading_in = item.button_level;
            if (press_evt) begin
               held_in        = 1'b1;
               press_start_in = now_t;
               long_fired_in  = 1'b0;
            end else if (release_evt) begin
               held_in = 1'b0;
            end else if (lp) begin
               long_fired_in = 1'b1;
            end
            result.short_press = sp;
            result.long_press  = lp;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff   <= 2'b11;
         accum_ff        <= '0;
         last_step_ff    <= '0;
         last_reading_ff <= 1'b1;
         last_change_ff  <= '0;
         press_start_ff  <= '0;
         held_ff         <= 1'b0;
         long_fired_ff   <= 1'b0;
      end else if (fire) begin
         last_phase_ff   <= last_phase_in;
         accum_ff        <= accum_in;
         last_step_ff    <= last_step_in;
         last_reading_ff <= last_reading_in;
         last_change_ff  <= last_change_in;
         press_start_ff  <= press_start_in;
         held_ff         <= held_in;
         long_fired_ff   <= long_fired_in;
      end
   end

endmodule
